// File: design/gdd_pkg.sv
`timescale 1ns / 1ps

package gdd_pkg;

  // Field widths of the date fields and the day count
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 23;

  // Default upper bound on the year
  localparam int MAX_YEAR_DEF = 9999;

  // Shared multiply-add unit operand and accumulator widths
  localparam int ACC_W = 32;
  localparam int OPA_W = 24;
  localparam int OPB_W = 16;

  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT, exact for x < 43699
  localparam logic [OPB_W-1:0] RECIP_100   = 16'd5243;
  localparam int               RECIP_SHIFT = 19;
  localparam int               QUOT_W      = 8;

  localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
  localparam logic [DAY_W-1:0]   LEAP_DAY = 5'd29;

  // Largest magnitude the signed count can hold
  localparam logic [OPA_W-1:0] COUNT_MAX = 24'd4194303;

  typedef struct packed {
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [YEAR_W-1:0]  start_year;
    logic [DAY_W-1:0]   end_day;
    logic [MONTH_W-1:0] end_month;
    logic [YEAR_W-1:0]  end_year;
    logic               count_end_day;
  } gdd_in_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] day_count;
    logic                      date_invalid;
  } gdd_out_t;

  // One operation of the shared unit: acc = c +/- a * b
  typedef struct packed {
    logic             en;
    logic             sub;
    logic [OPA_W-1:0] a;
    logic [OPB_W-1:0] b;
    logic [ACC_W-1:0] c;
  } gdd_op_t;

endpackage

// File: design/gdd_muladd.sv
`timescale 1ns / 1ps

module gdd_muladd (
  input  logic                      clk,
  input  gdd_pkg::gdd_op_t          op,
  output logic [gdd_pkg::ACC_W-1:0] acc
);
  import gdd_pkg::*;

  logic [OPA_W+OPB_W-1:0] prod;
  logic [ACC_W-1:0]       prod_lo;
  logic [ACC_W-1:0]       acc_r;
  logic [ACC_W-1:0]       acc_nxt;

  // Product, then add or subtract onto the addend (wraps mod 2^ACC_W)
  assign prod    = op.a * op.b;
  assign prod_lo = prod[ACC_W-1:0];
  assign acc_nxt = op.sub ? (op.c - prod_lo) : (op.c + prod_lo);

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// File: design/gdd_seq.sv
`timescale 1ns / 1ps

module gdd_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  gdd_pkg::gdd_in_t  item,
  output logic              done,
  output gdd_pkg::gdd_out_t result
);
  import gdd_pkg::*;

  // Per-date step codes; date A runs 0..10, date B runs 11..21
  localparam logic [3:0] K_RECIP_Y  = 4'd0;
  localparam logic [3:0] K_MUL100   = 4'd1;
  localparam logic [3:0] K_MUL400   = 4'd2;
  localparam logic [3:0] K_RECIP_P  = 4'd3;
  localparam logic [3:0] K_MUL365   = 4'd4;
  localparam logic [3:0] K_ADD_P4   = 4'd5;
  localparam logic [3:0] K_SUB_Q    = 4'd6;
  localparam logic [3:0] K_ADD_Q4   = 4'd7;
  localparam logic [3:0] K_ADD_DBM  = 4'd8;
  localparam logic [3:0] K_ADD_DAY  = 4'd9;
  localparam logic [3:0] K_ADD_LEAP = 4'd10;

  localparam logic [4:0] S_DATE_B = 5'd11;
  localparam logic [4:0] S_DIFF   = 5'd22;
  localparam logic [4:0] S_ABS    = 5'd23;
  localparam logic [4:0] S_INC    = 5'd24;
  localparam logic [4:0] S_SIGN   = 5'd25;
  localparam logic [4:0] S_DONE   = 5'd26;

  // Days before each month in a common year
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  logic             busy_r, busy_nxt;
  logic [4:0]       step_r, step_nxt;
  logic [QUOT_W-1:0] qy_r, qp_r;
  logic             div100_r, div400_r;
  logic             bad_r, bad_nxt;
  logic             neg_r;
  logic [OPA_W-1:0] serial_a_r;

  logic [ACC_W-1:0]   acc;
  gdd_op_t            op;
  logic               sel_b;
  logic [3:0]         k;
  logic [4:0]         k_wide;
  logic [DAY_W-1:0]   cur_d;
  logic [MONTH_W-1:0] cur_m;
  logic [YEAR_W-1:0]  cur_y;
  logic [YEAR_W-1:0]  cur_p;
  logic [QUOT_W-1:0]  q_now;
  logic               leap;
  logic [OPA_W:0]     mag;
  logic [OPA_W-1:0]   mag_sat;

  gdd_muladd u_unit (
    .clk (clk),
    .op  (op),
    .acc (acc)
  );

  // Date being worked on and its local step
  assign sel_b  = (step_r >= S_DATE_B);
  assign k_wide = sel_b ? (step_r - S_DATE_B) : step_r;
  assign k      = k_wide[3:0];
  assign cur_d  = sel_b ? item.end_day   : item.start_day;
  assign cur_m  = sel_b ? item.end_month : item.start_month;
  assign cur_y  = sel_b ? item.end_year  : item.start_year;
  assign cur_p  = cur_y - YEAR_W'(1);
  assign q_now  = acc[RECIP_SHIFT +: QUOT_W];
  assign leap   = ((cur_y[1:0] == 2'd0) && !div100_r) || div400_r;

  // Magnitude clamp before the sign is applied
  assign mag     = acc[OPA_W:0];
  assign mag_sat = (mag > {1'b0, COUNT_MAX}) ? COUNT_MAX : mag[OPA_W-1:0];

  // Operation issued to the shared unit for this step
  always_comb begin
    op     = '0;
    op.en  = busy_r && (step_r != S_DONE);
    op.b   = OPB_W'(1);
    op.c   = acc;
    if (step_r >= S_DIFF) begin
      case (step_r)
        S_DIFF: begin
          op.a   = serial_a_r;
          op.sub = 1'b1;
        end
        S_ABS: begin
          op.a   = acc[OPA_W-1:0];
          op.sub = acc[ACC_W-1];
          // negative difference is taken from 2^OPA_W so the upper bits come out clear
          op.c   = acc[ACC_W-1] ? ACC_W'(1 << OPA_W) : '0;
        end
        S_INC: begin
          op.a = OPA_W'(item.count_end_day);
        end
        S_SIGN: begin
          op.a   = mag_sat;
          op.sub = neg_r;
          op.c   = '0;
        end
        default: begin
          op.a = '0;
        end
      endcase
    end else begin
      case (k)
        K_RECIP_Y: begin
          op.a = OPA_W'(cur_y);
          op.b = RECIP_100;
          op.c = '0;
        end
        K_MUL100: begin
          op.a = OPA_W'(q_now);
          op.b = OPB_W'(100);
          op.c = '0;
        end
        K_MUL400: begin
          op.a = OPA_W'(qy_r >> 2);
          op.b = OPB_W'(400);
          op.c = '0;
        end
        K_RECIP_P: begin
          op.a = OPA_W'(cur_p);
          op.b = RECIP_100;
          op.c = '0;
        end
        K_MUL365: begin
          op.a = OPA_W'(cur_p);
          op.b = OPB_W'(365);
          op.c = '0;
        end
        K_ADD_P4:   op.a = OPA_W'(cur_p >> 2);
        K_SUB_Q: begin
          op.a   = OPA_W'(qp_r);
          op.sub = 1'b1;
        end
        K_ADD_Q4:   op.a = OPA_W'(qp_r >> 2);
        K_ADD_DBM:  op.a = OPA_W'(days_before(cur_m));
        K_ADD_DAY:  op.a = OPA_W'(cur_d);
        K_ADD_LEAP: op.a = OPA_W'((cur_m > FEBRUARY) && leap);
        default:    op.a = '0;
      endcase
    end
  end

  // Step counter and the invalid leap day flag
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    bad_nxt  = bad_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      bad_nxt  = 1'b0;
    end else if (busy_r) begin
      if (step_r == S_DONE) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_r + 5'd1;
      end
      if ((step_r < S_DIFF) && (k == K_ADD_LEAP) && (cur_m == FEBRUARY) &&
          (cur_d == LEAP_DAY) && !leap) begin
        bad_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      bad_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      bad_r  <= bad_nxt;
    end
  end

  // Side registers latched from the unit's result
  always_ff @(posedge clk) begin
    if (busy_r && (step_r < S_DIFF)) begin
      if (k == K_MUL100)  qy_r     <= q_now;
      if (k == K_MUL400)  div100_r <= (acc[OPA_W-1:0] == OPA_W'(cur_y));
      if (k == K_RECIP_P) div400_r <= (acc[OPA_W-1:0] == OPA_W'(cur_y));
      if (k == K_MUL365)  qp_r     <= q_now;
    end
    if (busy_r && (step_r == S_DATE_B)) begin
      serial_a_r <= acc[OPA_W-1:0];
    end
    if (busy_r && (step_r == S_ABS)) begin
      neg_r <= acc[ACC_W-1];
    end
  end

  assign done                = busy_r && (step_r == S_DONE);
  assign result.day_count    = bad_r ? '0 : acc[COUNT_W-1:0];
  assign result.date_invalid = bad_r;

endmodule

// File: design/gregorian_date_difference.sv
`timescale 1ns / 1ps
// Gregorian date difference: signed days from the first date to the second.
// Dates that fail the range check go straight to the result; valid dates take a 27-step
// walk through the one shared multiply-add unit. One item at a time, in_ready low
// meanwhile, so a new item is taken only after the result has been taken.
// Reset (rst_n, synchronous, active low) empties the block.
module gregorian_date_difference #(
  parameter int MAX_YEAR = gdd_pkg::MAX_YEAR_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gdd_pkg::gdd_in_t  in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output gdd_pkg::gdd_out_t out_item
);
  import gdd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Longest possible day of a month, leap year assumed for February
  function automatic logic [DAY_W-1:0] day_limit(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] r;
    case (m)
      FEBRUARY:                r = LEAP_DAY;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      default:                 r = 5'd31;
    endcase
    return r;
  endfunction

  function automatic logic date_ok(input logic [DAY_W-1:0] d,
                                   input logic [MONTH_W-1:0] m,
                                   input logic [YEAR_W-1:0] y);
    logic ok;
    ok = (m inside {[4'd1:4'd12]}) && (y != '0) &&
         ({1'b0, y} <= 15'(MAX_YEAR)) && (d != '0) && (d <= day_limit(m));
    return ok;
  endfunction

  logic [1:0] state_r, state_nxt;
  gdd_in_t    item_r;
  gdd_out_t   out_r;
  logic       accept;
  logic       in_ok;
  logic       seq_start;
  logic       seq_done;
  gdd_out_t   seq_result;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
  assign out_item  = out_r;
  assign accept    = in_valid && in_ready;
  assign in_ok     = date_ok(in_item.start_day, in_item.start_month, in_item.start_year) &&
                     date_ok(in_item.end_day, in_item.end_month, in_item.end_year);
  assign seq_start = accept && in_ok;

  gdd_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (seq_start),
    .item   (item_r),
    .done   (seq_done),
    .result (seq_result)
  );

  // Handshake sequencing
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = in_ok ? ST_RUN : ST_DONE;
      ST_RUN:  if (seq_done) state_nxt = ST_DONE;
      ST_DONE: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Input item and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
      if (!in_ok) begin
        out_r.day_count    <= '0;
        out_r.date_invalid <= 1'b1;
      end
    end
    if ((state_r == ST_RUN) && seq_done) begin
      out_r <= seq_result;
    end
  end

endmodule
